// File: hdl/brf_pkg.sv
// brf_pkg: shared types and constants for the byte register file alu
// no dependencies; imported by brf_ctrl, brf_dp and the top level, not by brf_ram

package brf_pkg;

  // register file geometry
  localparam int REGISTER_COUNT = 16;
  localparam int REG_AW         = $clog2(REGISTER_COUNT);
  localparam int DATA_W         = 8;
  localparam int INDEX_W        = 16;
  localparam int CMD_W          = 3;
  localparam int OP_W           = 4;

  // the last register doubles as the carry / borrow flag
  localparam logic [REG_AW-1:0] FLAG_REG = REG_AW'(REGISTER_COUNT - 1);

  // item commands; codes without a member act as read only
  typedef enum logic [CMD_W-1:0] {
    CMD_SET  = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_REG  = 3'd2,
    CMD_IDX  = 3'd3,
    CMD_READ = 3'd4
  } cmd_t;

  // register-on-register operations; other codes change nothing
  typedef enum logic [OP_W-1:0] {
    OP_COPY = 4'd0,
    OP_OR   = 4'd1,
    OP_AND  = 4'd2,
    OP_XOR  = 4'd3,
    OP_ADD  = 4'd4,
    OP_SUB  = 4'd5,
    OP_SHR  = 4'd6,
    OP_SUBN = 4'd7,
    OP_SHL  = 4'd14
  } alu_op_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_FLAG,
    ST_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch_in;  // capture the accepted transaction
    logic exec;      // operands valid: compute, write x
    logic flag_wr;   // write the flag register
    logic load_out;  // move results into the output register
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic flag_needed;  // current operation also writes the flag
  } ctl_sts_t;

endpackage

// File: hdl/brf_ram.sv
// brf_ram: generic single-write, dual-read ram with registered read data
// no dependencies

module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: hdl/brf_ctrl.sv
// brf_ctrl: sequencing state machine and result handshake
// depends on brf_pkg

module brf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output brf_pkg::ctl_cmd_t   cmd,
  input  brf_pkg::ctl_sts_t   sts
);

  import brf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // state and result valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.flag_needed ? ST_FLAG : ST_DONE;
      end
      ST_FLAG: begin
        cmd.flag_wr = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result valid: set on load, cleared when the transaction is taken
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/brf_dp.sv
// brf_dp: register file storage, alu and result registers
// depends on brf_pkg and brf_ram

module brf_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  brf_pkg::ctl_cmd_t             cmd,
  output brf_pkg::ctl_sts_t             sts,
  input  logic [brf_pkg::CMD_W-1:0]     in_command,
  input  logic [brf_pkg::REG_AW-1:0]    in_reg_x,
  input  logic [brf_pkg::REG_AW-1:0]    in_reg_y,
  input  logic [brf_pkg::OP_W-1:0]      in_operation,
  input  logic [brf_pkg::DATA_W-1:0]    in_immediate,
  input  logic [brf_pkg::INDEX_W-1:0]   in_index_value,
  output logic [brf_pkg::DATA_W-1:0]    out_x_value,
  output logic [brf_pkg::DATA_W-1:0]    out_y_value,
  output logic                          out_regs_equal,
  output logic [brf_pkg::DATA_W-1:0]    out_flag_value,
  output logic [brf_pkg::INDEX_W-1:0]   out_index_out
);

  import brf_pkg::*;

  // latched transaction
  cmd_t                cmd_r;
  logic [REG_AW-1:0]   x_r;
  logic [REG_AW-1:0]   y_r;
  alu_op_t             op_r;
  logic [DATA_W-1:0]   imm_r;
  logic [INDEX_W-1:0]  index_r;

  // storage side
  logic [REGISTER_COUNT-1:0] valid_r;
  logic                      x_ok_r, y_ok_r;
  logic [DATA_W-1:0]         ram_x, ram_y;
  logic [DATA_W-1:0]         vf_r;
  logic                      ram_we;
  logic [REG_AW-1:0]         ram_waddr;
  logic [DATA_W-1:0]         ram_wdata;

  // alu
  logic [DATA_W-1:0] vx, vy;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] new_x;
  logic              x_wr;
  logic              flag_bit;
  logic              flag_wr;

  // results after the step
  logic [DATA_W-1:0] fin_x, fin_y, fin_f;
  logic [DATA_W-1:0] res_x_r, res_y_r, res_f_r;
  logic              flag_bit_r;

  // capture the accepted transaction; index updates at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= '0;
    end else if (cmd.latch_in && cmd_t'(in_command) == CMD_IDX) begin
      index_r <= in_index_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r <= cmd_t'(in_command);
      x_r   <= in_reg_x;
      y_r   <= in_reg_y;
      op_r  <= alu_op_t'(in_operation);
      imm_r <= in_immediate;
    end
  end

  // register file; an entry never written reads as zero
  brf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (REGISTER_COUNT)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (x_r),
    .rdata_a (ram_x),
    .raddr_b (y_r),
    .rdata_b (ram_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vf_r    <= '0;
    end else if (ram_we) begin
      valid_r[ram_waddr] <= 1'b1;
      if (ram_waddr == FLAG_REG) begin
        vf_r <= ram_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_ok_r <= valid_r[x_r];
    y_ok_r <= valid_r[y_r];
  end

  assign vx  = x_ok_r ? ram_x : '0;
  assign vy  = y_ok_r ? ram_y : '0;
  assign sum = {1'b0, vx} + {1'b0, vy};

  // alu: new value of x and the flag
  always_comb begin
    new_x    = vx;
    x_wr     = 1'b0;
    flag_bit = 1'b0;
    flag_wr  = 1'b0;
    case (cmd_r)
      CMD_SET: begin
        new_x = imm_r;
        x_wr  = 1'b1;
      end
      CMD_ADD: begin
        new_x = vx + imm_r;
        x_wr  = 1'b1;
      end
      CMD_REG: begin
        x_wr = 1'b1;
        unique case (op_r)
          OP_COPY: new_x = vy;
          OP_OR:   new_x = vx | vy;
          OP_AND:  new_x = vx & vy;
          OP_XOR:  new_x = vx ^ vy;
          OP_ADD: begin
            new_x    = sum[DATA_W-1:0];
            flag_bit = sum[DATA_W];
            flag_wr  = 1'b1;
          end
          OP_SUB: begin
            new_x    = vx - vy;
            flag_bit = (vx >= vy);
            flag_wr  = 1'b1;
          end
          OP_SUBN: begin
            new_x    = vy - vx;
            flag_bit = (vy >= vx);
            flag_wr  = 1'b1;
          end
          OP_SHR: begin
            new_x    = {1'b0, vx[DATA_W-1:1]};
            flag_bit = vx[0];
            flag_wr  = 1'b1;
          end
          OP_SHL: begin
            new_x    = {vx[DATA_W-2:0], 1'b0};
            flag_bit = vx[DATA_W-1];
            flag_wr  = 1'b1;
          end
          default: begin
            x_wr = 1'b0;
          end
        endcase
      end
      default: begin
        x_wr = 1'b0;
      end
    endcase
  end

  assign sts.flag_needed = flag_wr;

  // ram write: x during exec, then the flag so that it lands last
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = x_r;
    ram_wdata = new_x;
    if (cmd.exec) begin
      ram_we = x_wr;
    end else if (cmd.flag_wr) begin
      ram_we    = 1'b1;
      ram_waddr = FLAG_REG;
      ram_wdata = {{(DATA_W-1){1'b0}}, flag_bit_r};
    end
  end

  // register values as they stand after both writes
  always_comb begin
    fin_x = x_wr ? new_x : vx;
    if (flag_wr && x_r == FLAG_REG) begin
      fin_x = {{(DATA_W-1){1'b0}}, flag_bit};
    end
    if (y_r == x_r) begin
      fin_y = fin_x;
    end else if (flag_wr && y_r == FLAG_REG) begin
      fin_y = {{(DATA_W-1){1'b0}}, flag_bit};
    end else begin
      fin_y = vy;
    end
    if (flag_wr) begin
      fin_f = {{(DATA_W-1){1'b0}}, flag_bit};
    end else if (x_wr && x_r == FLAG_REG) begin
      fin_f = new_x;
    end else begin
      fin_f = vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_x_r    <= fin_x;
      res_y_r    <= fin_y;
      res_f_r    <= fin_f;
      flag_bit_r <= flag_bit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_x_value    <= res_x_r;
      out_y_value    <= res_y_r;
      out_regs_equal <= (res_x_r == res_y_r);
      out_flag_value <= res_f_r;
      out_index_out  <= index_r;
    end
  end

endmodule

// File: hdl/byte_register_file_alu.sv
// byte_register_file_alu: top level, sixteen byte registers, index register and alu
// depends on brf_pkg, brf_ctrl, brf_dp (which holds brf_ram)
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall   | command, reg_x, reg_y, operation,
//           |           |                      | immediate, index_value
//   out_    | output    | out_valid / out_stall | x_value, y_value, regs_equal,
//           |           |                      | flag_value, index_out
//
// each transaction passes through accept, ram read, execute and write x, flag write
// (only when the operation also writes the flag) and load output register.
// the single ram write port is why flag operations need the separate flag write step.
// rst_n is synchronous; all registers and the index read as zero after reset.
// a result waiting under out_stall stays in the output register while the
// next transaction is accepted and run; it waits only at the final load.

module byte_register_file_alu (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [brf_pkg::CMD_W-1:0]     in_command,
  input  logic [brf_pkg::REG_AW-1:0]    in_reg_x,
  input  logic [brf_pkg::REG_AW-1:0]    in_reg_y,
  input  logic [brf_pkg::OP_W-1:0]      in_operation,
  input  logic [brf_pkg::DATA_W-1:0]    in_immediate,
  input  logic [brf_pkg::INDEX_W-1:0]   in_index_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [brf_pkg::DATA_W-1:0]    out_x_value,
  output logic [brf_pkg::DATA_W-1:0]    out_y_value,
  output logic                          out_regs_equal,
  output logic [brf_pkg::DATA_W-1:0]    out_flag_value,
  output logic [brf_pkg::INDEX_W-1:0]   out_index_out
);

  import brf_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencing
  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // storage and arithmetic
  brf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_command     (in_command),
    .in_reg_x       (in_reg_x),
    .in_reg_y       (in_reg_y),
    .in_operation   (in_operation),
    .in_immediate   (in_immediate),
    .in_index_value (in_index_value),
    .out_x_value    (out_x_value),
    .out_y_value    (out_y_value),
    .out_regs_equal (out_regs_equal),
    .out_flag_value (out_flag_value),
    .out_index_out  (out_index_out)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for byte_register_file_alu with a shadow register file,
// bursty sender and stalling receiver; depends on brf_pkg and the block's rtl

module tb;
  import brf_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 11;
  localparam int LIMIT_CYCLES = 250000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 100;
  localparam int PHASE_ITEMS  = 280;

  // codes the block must treat as no-ops
  localparam logic [OP_W-1:0]  OP_UNUSED_LO = 4'd8;
  localparam logic [OP_W-1:0]  OP_UNUSED_HI = 4'd15;
  localparam logic [CMD_W-1:0] CMD_UNUSED   = 3'd7;

  localparam alu_op_t LEGAL_OPS [9] = '{OP_COPY, OP_OR, OP_AND, OP_XOR, OP_ADD,
                                        OP_SUB, OP_SHR, OP_SUBN, OP_SHL};

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PATTERN
  } stall_mode_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [REG_AW-1:0]  reg_x;
    logic [REG_AW-1:0]  reg_y;
    logic [OP_W-1:0]    operation;
    logic [DATA_W-1:0]  immediate;
    logic [INDEX_W-1:0] index_value;
  } instr_t;

  typedef struct packed {
    logic [DATA_W-1:0]  x_value;
    logic [DATA_W-1:0]  y_value;
    logic               regs_equal;
    logic [DATA_W-1:0]  flag_value;
    logic [INDEX_W-1:0] index_out;
  } snapshot_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command     = '0;
  logic [REG_AW-1:0]   in_reg_x       = '0;
  logic [REG_AW-1:0]   in_reg_y       = '0;
  logic [OP_W-1:0]     in_operation   = '0;
  logic [DATA_W-1:0]   in_immediate   = '0;
  logic [INDEX_W-1:0]  in_index_value = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [DATA_W-1:0]   out_x_value;
  logic [DATA_W-1:0]   out_y_value;
  logic                out_regs_equal;
  logic [DATA_W-1:0]   out_flag_value;
  logic [INDEX_W-1:0]  out_index_out;

  // shadow copy of the block's state
  logic [DATA_W-1:0]   shadow_regs [REGISTER_COUNT];
  logic [INDEX_W-1:0]  shadow_index;
  snapshot_t           expected_snapshots [$];

  int          burst_left     = 0;
  int          gap_max        = 0;
  stall_mode_t stall_mode     = STALL_NONE;
  int          hold_seq       = 0;
  int          hold_seen      = 0;
  int          hold_left      = 0;
  int          stall_phase    = 0;
  int          mismatch_count = 0;
  int          cycle_count    = 0;

  byte_register_file_alu u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_reg_x       (in_reg_x),
    .in_reg_y       (in_reg_y),
    .in_operation   (in_operation),
    .in_immediate   (in_immediate),
    .in_index_value (in_index_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x_value    (out_x_value),
    .out_y_value    (out_y_value),
    .out_regs_equal (out_regs_equal),
    .out_flag_value (out_flag_value),
    .out_index_out  (out_index_out)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // run one instruction on the shadow file and return the register snapshot
  function automatic snapshot_t apply_instruction(input instr_t it);
    snapshot_t          snap;
    logic [DATA_W-1:0]  vx;
    logic [DATA_W-1:0]  vy;
    logic [DATA_W-1:0]  res;
    logic [DATA_W:0]    sum;
    logic               carry;
    logic               flag_wr;
    vx      = shadow_regs[it.reg_x];
    vy      = shadow_regs[it.reg_y];
    res     = vx;
    carry   = 1'b0;
    flag_wr = 1'b0;
    case (it.command)
      CMD_SET: shadow_regs[it.reg_x] = it.immediate;
      CMD_ADD: shadow_regs[it.reg_x] = vx + it.immediate;
      CMD_REG: begin
        case (it.operation)
          OP_COPY: res = vy;
          OP_OR:   res = vx | vy;
          OP_AND:  res = vx & vy;
          OP_XOR:  res = vx ^ vy;
          OP_ADD: begin
            sum     = {1'b0, vx} + {1'b0, vy};
            res     = sum[DATA_W-1:0];
            carry   = sum[DATA_W];
            flag_wr = 1'b1;
          end
          OP_SUB: begin
            res     = vx - vy;
            carry   = (vx >= vy);
            flag_wr = 1'b1;
          end
          OP_SUBN: begin
            res     = vy - vx;
            carry   = (vy >= vx);
            flag_wr = 1'b1;
          end
          OP_SHR: begin
            res     = vx >> 1;
            carry   = vx[0];
            flag_wr = 1'b1;
          end
          OP_SHL: begin
            res     = vx << 1;
            carry   = vx[DATA_W-1];
            flag_wr = 1'b1;
          end
          default: res = vx;
        endcase
        shadow_regs[it.reg_x] = res;
        // flag lands after the result, so it wins when x is the flag register
        if (flag_wr) shadow_regs[FLAG_REG] = DATA_W'(carry);
      end
      CMD_IDX: shadow_index = it.index_value;
      default: ;
    endcase
    snap.x_value    = shadow_regs[it.reg_x];
    snap.y_value    = shadow_regs[it.reg_y];
    snap.regs_equal = (snap.x_value == snap.y_value);
    snap.flag_value = shadow_regs[FLAG_REG];
    snap.index_out  = shadow_index;
    return snap;
  endfunction

  function automatic instr_t make_instr(input logic [CMD_W-1:0] cmd,
                                        input logic [REG_AW-1:0] x,
                                        input logic [REG_AW-1:0] y,
                                        input logic [OP_W-1:0] op,
                                        input logic [DATA_W-1:0] imm,
                                        input logic [INDEX_W-1:0] idx);
    instr_t it;
    it.command     = cmd;
    it.reg_x       = x;
    it.reg_y       = y;
    it.operation   = op;
    it.immediate   = imm;
    it.index_value = idx;
    return it;
  endfunction

  // mostly legal commands and operations, with edge bytes and the flag register favored
  function automatic instr_t random_instr();
    instr_t it;
    int     pick;
    pick = $urandom_range(0, 99);
    if (pick < 12)      it.command = CMD_SET;
    else if (pick < 22) it.command = CMD_ADD;
    else if (pick < 72) it.command = CMD_REG;
    else if (pick < 80) it.command = CMD_IDX;
    else if (pick < 92) it.command = CMD_READ;
    else
      it.command = CMD_W'($urandom_range(int'(CMD_READ) + 1, (1 << CMD_W) - 1));
    if ($urandom_range(0, 9) != 0)
      it.operation = LEGAL_OPS[$urandom_range(0, $size(LEGAL_OPS) - 1)];
    else
      it.operation = OP_W'($urandom());
    if ($urandom_range(0, 7) == 0) it.reg_x = FLAG_REG;
    else                           it.reg_x = REG_AW'($urandom());
    if ($urandom_range(0, 5) == 0) it.reg_y = it.reg_x;
    else                           it.reg_y = REG_AW'($urandom());
    case ($urandom_range(0, 7))
      0:       it.immediate = '0;
      1:       it.immediate = '1;
      2:       it.immediate = 8'h80;
      default: it.immediate = DATA_W'($urandom());
    endcase
    it.index_value = INDEX_W'($urandom());
    return it;
  endfunction

  // offer one transaction, record its snapshot once accepted, idle between bursts
  task automatic send_instr(input instr_t it);
    int        gap_len;
    snapshot_t snap;
    in_valid       <= 1'b1;
    in_command     <= it.command;
    in_reg_x       <= it.reg_x;
    in_reg_y       <= it.reg_y;
    in_operation   <= it.operation;
    in_immediate   <= it.immediate;
    in_index_value <= it.index_value;
    do @(posedge clk); while (in_stall !== 1'b0);
    snap = apply_instruction(it);
    expected_snapshots = {expected_snapshots, snap};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) begin
        gap_len = $urandom_range(1, gap_max);
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [INDEX_W-1:0] want_v,
                                 input logic [INDEX_W-1:0] got_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want_v, got_v);
  endtask

  task automatic check_snapshot();
    snapshot_t want;
    if (expected_snapshots.size() == 0) begin
      report_mismatch("unexpected result, x_value", '0, INDEX_W'(out_x_value));
      return;
    end
    want = expected_snapshots.pop_front();
    if (out_x_value !== want.x_value)
      report_mismatch("x_value", INDEX_W'(want.x_value), INDEX_W'(out_x_value));
    if (out_y_value !== want.y_value)
      report_mismatch("y_value", INDEX_W'(want.y_value), INDEX_W'(out_y_value));
    if (out_regs_equal !== want.regs_equal)
      report_mismatch("regs_equal", INDEX_W'(want.regs_equal), INDEX_W'(out_regs_equal));
    if (out_flag_value !== want.flag_value)
      report_mismatch("flag_value", INDEX_W'(want.flag_value), INDEX_W'(out_flag_value));
    if (out_index_out !== want.index_out)
      report_mismatch("index_out", want.index_out, out_index_out);
  endtask

  // long hold: counts its own cycles once a new hold is requested
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES - 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result side: check each accepted transaction, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) check_snapshot();
    stall_phase <= stall_phase + 1;
    if (hold_seen != hold_seq || hold_left > 0) begin
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((stall_phase % 11) < 4);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_reset_state();
    send_instr(make_instr(CMD_READ, 4'd0, FLAG_REG, OP_COPY, 8'h00, 16'h0000));
  endtask

  // immediates and every register operation with its flag corner
  task automatic test_alu_ops();
    send_instr(make_instr(CMD_SET,  4'd1, 4'd0, OP_COPY, 8'hFF, 16'h0000));
    send_instr(make_instr(CMD_ADD,  4'd2, 4'd1, OP_COPY, 8'h01, 16'hFFFF));
    send_instr(make_instr(CMD_REG,  4'd1, 4'd2, OP_ADD,  8'h00, 16'h0000));
    send_instr(make_instr(CMD_SET,  4'd3, 4'd0, OP_COPY, 8'h80, 16'h0000));
    send_instr(make_instr(CMD_REG,  4'd3, 4'd0, OP_SHL,  8'h00, 16'h0000));
    send_instr(make_instr(CMD_SET,  4'd4, 4'd0, OP_COPY, 8'hFF, 16'h0000));
    send_instr(make_instr(CMD_REG,  4'd4, 4'd0, OP_SHR,  8'h00, 16'h0000));
    send_instr(make_instr(CMD_SET,  4'd5, 4'd0, OP_COPY, 8'h10, 16'h0000));
    send_instr(make_instr(CMD_SET,  4'd6, 4'd0, OP_COPY, 8'h10, 16'h0000));
    // equal operands: no borrow
    send_instr(make_instr(CMD_REG,  4'd5, 4'd6, OP_SUB,  8'h00, 16'h0000));
    send_instr(make_instr(CMD_REG,  4'd5, 4'd6, OP_SUBN, 8'h00, 16'h0000));
    send_instr(make_instr(CMD_REG,  4'd2, 4'd6, OP_SUB,  8'h00, 16'h0000));
    // logic ops and copy leave the flag alone
    send_instr(make_instr(CMD_REG,  4'd1, 4'd4, OP_OR,   8'h00, 16'h0000));
    send_instr(make_instr(CMD_REG,  4'd4, 4'd2, OP_AND,  8'h00, 16'h0000));
    send_instr(make_instr(CMD_REG,  4'd6, 4'd6, OP_XOR,  8'h00, 16'h0000));
    send_instr(make_instr(CMD_REG,  4'd7, 4'd4, OP_COPY, 8'h00, 16'h0000));
  endtask

  // flag register as destination: a flag-writing operation's flag overwrites the result
  task automatic test_flag_destination();
    send_instr(make_instr(CMD_REG, FLAG_REG, 4'd4, OP_ADD,  8'h00, 16'h0000));
    send_instr(make_instr(CMD_REG, FLAG_REG, 4'd1, OP_SUBN, 8'h00, 16'h0000));
    send_instr(make_instr(CMD_ADD, FLAG_REG, 4'd0, OP_COPY, 8'hFF, 16'h0000));
  endtask

  task automatic test_unused_codes_and_index();
    send_instr(make_instr(CMD_REG,    4'd1, 4'd2, OP_UNUSED_LO, 8'h00, 16'h0000));
    send_instr(make_instr(CMD_REG,    4'd1, 4'd2, OP_UNUSED_HI, 8'hFF, 16'hFFFF));
    send_instr(make_instr(CMD_IDX,    4'd0, 4'd0, OP_COPY,      8'h00, 16'hFFFF));
    send_instr(make_instr(CMD_UNUSED, 4'd3, 4'd4, OP_ADD,       8'hFF, 16'h0000));
    send_instr(make_instr(CMD_IDX,    4'd15, 4'd15, OP_SHL,     8'hFF, 16'h0000));
  endtask

  // random traffic across the idling and stalling mixes
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin stall_mode <= STALL_NONE;    gap_max = 0; end
        1: begin stall_mode <= STALL_LIGHT;   gap_max = 3; end
        2: begin stall_mode <= STALL_HEAVY;   gap_max = 7; end
        default: begin stall_mode <= STALL_PATTERN; gap_max = 5; end
      endcase
      repeat (PHASE_ITEMS) send_instr(random_instr());
    end
  endtask

  task automatic test_flag_register_ops();
    instr_t it;
    stall_mode <= STALL_LIGHT;
    gap_max = 4;
    repeat (150) begin
      it = random_instr();
      it.command = CMD_REG;
      it.reg_x   = FLAG_REG;
      send_instr(it);
    end
  endtask

  task automatic test_shared_operand();
    instr_t it;
    stall_mode <= STALL_PATTERN;
    gap_max = 2;
    repeat (150) begin
      it = random_instr();
      it.reg_y = it.reg_x;
      send_instr(it);
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input backs up
  task automatic test_backpressure();
    gap_max = 0;
    stall_mode <= STALL_NONE;
    hold_seq <= hold_seq + 1;
    repeat (100) send_instr(random_instr());
    stall_mode <= STALL_LIGHT;
    hold_seq <= hold_seq + 1;
    repeat (100) send_instr(random_instr());
  endtask

  initial begin
    for (int i = 0; i < REGISTER_COUNT; i++) shadow_regs[i] = '0;
    shadow_index = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_alu_ops();
    test_flag_destination();
    test_unused_codes_and_index();
    test_random_traffic();
    test_flag_register_ops();
    test_shared_operand();
    test_backpressure();

    in_valid <= 1'b0;
    stall_mode <= STALL_LIGHT;
    while (expected_snapshots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
